>>> hdl/bbc_pkg.sv
// ----------------------------------------------------------------------------
// bbc_pkg: shared types and constants
// Request codes, result codes, queue command and table entry layouts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package bbc_pkg;

  // Request codes on the input channel.
  localparam logic [1:0] REQ_LOOKUP = 2'd0;
  localparam logic [1:0] REQ_INSERT = 2'd1;
  localparam logic [1:0] REQ_CLEAR  = 2'd2;

  // Result status codes.
  localparam logic [2:0] ST_MISS     = 3'd0;
  localparam logic [2:0] ST_HIT      = 3'd1;
  localparam logic [2:0] ST_STORED   = 3'd2;
  localparam logic [2:0] ST_REJECTED = 3'd3;
  localparam logic [2:0] ST_CLEARED  = 3'd4;

  // Width of the recency stamp kept with each entry.
  localparam int unsigned STAMP_W = 40;

  // Command kinds after classification in the front end.
  typedef enum logic [2:0] {
    OP_LOOKUP,
    OP_INSERT,
    OP_REJECT,
    OP_CLEAR,
    OP_NONE
  } op_e;

  // Back end sequencer states.
  typedef enum logic [2:0] {
    B_IDLE,
    B_KEY,
    B_EVCHK,
    B_OLD,
    B_FILL,
    B_HIT
  } bstate_e;

  // Classified command passed through the queue.
  typedef struct packed {
    op_e         op;
    logic [31:0] gen;
    logic [31:0] ord;
    logic [1:0]  stage;
    logic [31:0] handle;
    logic [63:0] size;
  } cmd_t;

  // One table entry as stored in the entry memory.
  typedef struct packed {
    logic [31:0]        gen;
    logic [31:0]        ord;
    logic [1:0]         stage;
    logic [63:0]        size;
    logic [31:0]        href;
    logic [STAMP_W-1:0] stamp;
  } ent_t;

endpackage

>>> hdl/byte_budget_lru_cache.sv
// ----------------------------------------------------------------------------
// byte_budget_lru_cache: size-weighted LRU cache of image handles
// Lookup, insert with byte-budget eviction, and clear, one result per request.
// ----------------------------------------------------------------------------
// Each request yields one result transaction. A clear, a rejected insert or
// an unused request code is answered from the idle state without a table
// scan. A lookup scans the whole entry memory for the key, one slot per
// cycle, and a hit then refreshes the entry's stamp before it answers. An
// insert scans for the key and then, for each evicted entry, scans the
// memory once more for the least-recent entry before it fills a free slot.
// Requests queue in front of the table sequencer, so intake continues while
// a command is carried out, until the queue and front end fill up.
`timescale 1ns / 1ps

module byte_budget_lru_cache #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready,
  // Request channel.
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  req_type_i,
  input  logic [31:0] key_generation_i,
  input  logic [31:0] key_ordinal_i,
  input  logic [1:0]  key_stage_i,
  input  logic        image_present_i,
  input  logic [31:0] image_handle_i,
  input  logic [30:0] image_width_i,
  input  logic [30:0] image_height_i,
  input  logic [63:0] image_byte_count_i,
  // Result channel.
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [31:0] hit_handle_o,
  output logic [63:0] retained_total_o,
  output logic [4:0]  evicted_count_o
);

  logic [63:0]   budget_q;
  logic          q_push, q_full, q_pop, q_valid;
  bbc_pkg::cmd_t q_in, q_out;

  // Budget register.
  assign pready = 1'b1;
  assign prdata = (paddr == 1'b0) ? budget_q : 64'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      budget_q <= '0;
    end else if (psel && penable && pwrite && (paddr == 1'b0)) begin
      budget_q <= pwdata;
    end
  end

  bbc_front u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .budget_i          (budget_q),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .req_type_i        (req_type_i),
    .key_generation_i  (key_generation_i),
    .key_ordinal_i     (key_ordinal_i),
    .key_stage_i       (key_stage_i),
    .image_present_i   (image_present_i),
    .image_handle_i    (image_handle_i),
    .image_width_i     (image_width_i),
    .image_height_i    (image_height_i),
    .image_byte_count_i(image_byte_count_i),
    .push_o            (q_push),
    .cmd_o             (q_in),
    .full_i            (q_full)
  );

  bbc_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .data_i (q_in),
    .full_o (q_full),
    .pop_i  (q_pop),
    .valid_o(q_valid),
    .data_o (q_out)
  );

  bbc_back #(
    .ENTRIES(ENTRIES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .budget_i        (budget_q),
    .q_valid_i       (q_valid),
    .q_data_i        (q_out),
    .q_pop_o         (q_pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .status_o        (status_o),
    .hit_handle_o    (hit_handle_o),
    .retained_total_o(retained_total_o),
    .evicted_count_o (evicted_count_o)
  );

  // Only an insert that stored its entry reports evictions.
  a_evict_only_stored: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (evicted_count_o != 5'd0) |-> status_o == bbc_pkg::ST_STORED)
    else $error("evictions reported on a result that is not a store");

  // A handle is returned only on a hit.
  a_handle_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (hit_handle_o != 32'd0) |-> status_o == bbc_pkg::ST_HIT)
    else $error("nonzero handle on a result that is not a hit");

  // A cleared cache retains nothing.
  a_clear_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == bbc_pkg::ST_CLEARED) |-> retained_total_o == 64'd0)
    else $error("clear left bytes retained");

endmodule

>>> hdl/bbc_ram.sv
// ----------------------------------------------------------------------------
// bbc_ram: generic single-write, single-read memory
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> hdl/bbc_fifo.sv
// ----------------------------------------------------------------------------
// bbc_fifo: two-entry command queue
// Decouples the classifying front end from the table sequencer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  bbc_pkg::cmd_t data_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output bbc_pkg::cmd_t data_o
);

  bbc_pkg::cmd_t mem_q [2];
  logic          wptr_q, wptr_d;
  logic          rptr_q, rptr_d;
  logic [1:0]    cnt_q, cnt_d;
  logic          do_push, do_pop;

  assign full_o  = (cnt_q == 2'd2);
  assign valid_o = (cnt_q != 2'd0);
  assign data_o  = mem_q[rptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  // Pointer and fill count update.
  always_comb begin
    wptr_d = do_push ? ~wptr_q : wptr_q;
    rptr_d = do_pop ? ~rptr_q : rptr_q;
    cnt_d  = cnt_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= 1'b0;
      rptr_q <= 1'b0;
      cnt_q  <= 2'd0;
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      cnt_q  <= cnt_d;
    end
  end

  // Storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wptr_q] <= data_i;
    end
  end

endmodule

>>> hdl/bbc_front.sv
// ----------------------------------------------------------------------------
// bbc_front: request intake and classification
// Registers each request, computes the image size and sorts the request
// into a queue command, rejecting inserts that fail the checks.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [63:0]   budget_i,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic [1:0]    req_type_i,
  input  logic [31:0]   key_generation_i,
  input  logic [31:0]   key_ordinal_i,
  input  logic [1:0]    key_stage_i,
  input  logic          image_present_i,
  input  logic [31:0]   image_handle_i,
  input  logic [30:0]   image_width_i,
  input  logic [30:0]   image_height_i,
  input  logic [63:0]   image_byte_count_i,
  output logic          push_o,
  output bbc_pkg::cmd_t cmd_o,
  input  logic          full_i
);

  // Stage one: raw request.
  logic        s1_v_q;
  logic [1:0]  s1_req_q;
  logic [31:0] s1_gen_q, s1_ord_q, s1_handle_q;
  logic [1:0]  s1_stage_q;
  logic        s1_pres_q;
  logic [30:0] s1_w_q, s1_h_q;
  logic [63:0] s1_given_q;

  // Stage two: request with its computed size.
  logic        s2_v_q;
  logic [1:0]  s2_req_q;
  logic [31:0] s2_gen_q, s2_ord_q, s2_handle_q;
  logic [1:0]  s2_stage_q;
  logic        s2_pres_q;
  logic [63:0] s2_given_q;
  logic [63:0] s2_size_q;

  logic        s2_free;
  logic        s1_move;
  logic        in_take;
  logic [61:0] prod;

  assign push_o     = s2_v_q && !full_i;
  assign s2_free    = !s2_v_q || push_o;
  assign s1_move    = s1_v_q && s2_free;
  assign in_stall_o = s1_v_q && !s2_free;
  assign in_take    = in_valid_i && !in_stall_o;
  assign prod       = {31'd0, s1_w_q} * {31'd0, s1_h_q};

  // Stage valid flags.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (in_take) begin
        s1_v_q <= 1'b1;
      end else if (s1_move) begin
        s1_v_q <= 1'b0;
      end
      if (s1_move) begin
        s2_v_q <= 1'b1;
      end else if (push_o) begin
        s2_v_q <= 1'b0;
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_req_q    <= req_type_i;
      s1_gen_q    <= key_generation_i;
      s1_ord_q    <= key_ordinal_i;
      s1_stage_q  <= key_stage_i;
      s1_pres_q   <= image_present_i;
      s1_handle_q <= image_handle_i;
      s1_w_q      <= image_width_i;
      s1_h_q      <= image_height_i;
      s1_given_q  <= image_byte_count_i;
    end
    if (s1_move) begin
      s2_req_q    <= s1_req_q;
      s2_gen_q    <= s1_gen_q;
      s2_ord_q    <= s1_ord_q;
      s2_stage_q  <= s1_stage_q;
      s2_pres_q   <= s1_pres_q;
      s2_handle_q <= s1_handle_q;
      s2_given_q  <= s1_given_q;
      s2_size_q   <= {prod, 2'b00};
    end
  end

  // Classification into a queue command.
  always_comb begin
    cmd_o.gen    = s2_gen_q;
    cmd_o.ord    = s2_ord_q;
    cmd_o.stage  = s2_stage_q;
    cmd_o.handle = s2_handle_q;
    cmd_o.size   = s2_size_q;
    case (s2_req_q)
      bbc_pkg::REQ_LOOKUP: cmd_o.op = bbc_pkg::OP_LOOKUP;
      bbc_pkg::REQ_INSERT: begin
        if (!s2_pres_q || (s2_size_q != s2_given_q) || (s2_size_q > budget_i)) begin
          cmd_o.op = bbc_pkg::OP_REJECT;
        end else begin
          cmd_o.op = bbc_pkg::OP_INSERT;
        end
      end
      bbc_pkg::REQ_CLEAR: cmd_o.op = bbc_pkg::OP_CLEAR;
      default:            cmd_o.op = bbc_pkg::OP_NONE;
    endcase
  end

endmodule

>>> hdl/bbc_back.sv
// ----------------------------------------------------------------------------
// bbc_back: table sequencer
// Carries out queued commands on the entry table: key search, least-recent
// eviction, fill and recency update, and holds the result for the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bbc_back #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic [63:0]   budget_i,
  input  logic          q_valid_i,
  input  bbc_pkg::cmd_t q_data_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output logic [2:0]    status_o,
  output logic [31:0]   hit_handle_o,
  output logic [63:0]   retained_total_o,
  output logic [4:0]    evicted_count_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam int unsigned EW = $bits(bbc_pkg::ent_t);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);

  bbc_pkg::bstate_e state_q, state_d;
  bbc_pkg::cmd_t    cmd_q, cmd_d;
  logic [CW-1:0]    idx_q, idx_d;
  logic             pv_q, pv_d;
  logic [IW-1:0]    pidx_q, pidx_d;
  logic             found_q, found_d;
  logic [IW-1:0]    fidx_q, fidx_d;
  bbc_pkg::ent_t    fword_q, fword_d;
  logic             bv_q, bv_d;
  logic [IW-1:0]    bidx_q, bidx_d;
  bbc_pkg::ent_t    bword_q, bword_d;
  logic [ENTRIES-1:0] valid_q, valid_d;
  logic [CW-1:0]    count_q, count_d;
  logic [63:0]      held_q, held_d;
  logic [63:0]      lim_q, lim_d;
  logic [4:0]       evict_q, evict_d;
  logic [bbc_pkg::STAMP_W-1:0] stamp_q, stamp_d;

  logic             ov_q, ov_d;
  logic [2:0]       status_q, status_d;
  logic [31:0]      hit_q, hit_d;
  logic [63:0]      total_q, total_d;
  logic [4:0]       evc_q, evc_d;

  logic             ram_we;
  logic [IW-1:0]    ram_waddr, ram_raddr;
  bbc_pkg::ent_t    ram_wdata, ram_rdata;
  logic [EW-1:0]    ram_rbits;

  logic             scan_done;
  logic             key_match;
  logic [IW-1:0]    free_idx;

  assign out_valid_o      = ov_q;
  assign status_o         = status_q;
  assign hit_handle_o     = hit_q;
  assign retained_total_o = total_q;
  assign evicted_count_o  = evc_q;
  assign ram_rdata        = bbc_pkg::ent_t'(ram_rbits);

  bbc_ram #(
    .WIDTH(EW),
    .DEPTH(ENTRIES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rbits)
  );

  // Scan end flag shared by the key and oldest-entry searches; key compare for the key search.
  assign scan_done = !pv_q && (idx_q == FULL_CNT);
  assign key_match = pv_q && valid_q[pidx_q] && (ram_rdata.gen == cmd_q.gen) &&
                     (ram_rdata.ord == cmd_q.ord) && (ram_rdata.stage == cmd_q.stage);

  // Lowest free slot.
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  // Next state and datapath control.
  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    idx_d     = idx_q;
    pv_d      = 1'b0;
    pidx_d    = pidx_q;
    found_d   = found_q;
    fidx_d    = fidx_q;
    fword_d   = fword_q;
    bv_d      = bv_q;
    bidx_d    = bidx_q;
    bword_d   = bword_q;
    valid_d   = valid_q;
    count_d   = count_q;
    held_d    = held_q;
    lim_d     = lim_q;
    evict_d   = evict_q;
    stamp_d   = stamp_q;
    ov_d      = ov_q && out_stall_i;
    status_d  = status_q;
    hit_d     = hit_q;
    total_d   = total_q;
    evc_d     = evc_q;
    q_pop_o   = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = fidx_q;
    ram_wdata = fword_q;
    ram_raddr = idx_q[IW-1:0];

    // Issue one read a cycle during a scan.
    if (state_q == bbc_pkg::B_KEY || state_q == bbc_pkg::B_OLD) begin
      if (idx_q != FULL_CNT) begin
        pv_d   = 1'b1;
        pidx_d = idx_q[IW-1:0];
        idx_d  = idx_q + 1'b1;
      end
    end

    case (state_q)
      bbc_pkg::B_IDLE: begin
        if (q_valid_i && !ov_q) begin
          q_pop_o  = 1'b1;
          cmd_d    = q_data_i;
          lim_d    = budget_i - q_data_i.size;
          idx_d    = '0;
          found_d  = 1'b0;
          evict_d  = '0;
          hit_d    = '0;
          evc_d    = '0;
          case (q_data_i.op)
            bbc_pkg::OP_LOOKUP, bbc_pkg::OP_INSERT: begin
              state_d = bbc_pkg::B_KEY;
            end
            bbc_pkg::OP_REJECT: begin
              ov_d     = 1'b1;
              status_d = bbc_pkg::ST_REJECTED;
              total_d  = held_q;
            end
            bbc_pkg::OP_CLEAR: begin
              valid_d  = '0;
              held_d   = '0;
              count_d  = '0;
              ov_d     = 1'b1;
              status_d = bbc_pkg::ST_CLEARED;
              total_d  = '0;
            end
            default: begin
              ov_d     = 1'b1;
              status_d = bbc_pkg::ST_MISS;
              total_d  = held_q;
            end
          endcase
        end
      end

      bbc_pkg::B_KEY: begin
        if (key_match && !found_q) begin
          found_d = 1'b1;
          fidx_d  = pidx_q;
          fword_d = ram_rdata;
        end
        if (scan_done) begin
          if (cmd_q.op == bbc_pkg::OP_LOOKUP) begin
            if (found_q) begin
              state_d = bbc_pkg::B_HIT;
            end else begin
              state_d  = bbc_pkg::B_IDLE;
              ov_d     = 1'b1;
              status_d = bbc_pkg::ST_MISS;
              total_d  = held_q;
            end
          end else begin
            // Replace: drop the entry with the same key first.
            if (found_q) begin
              valid_d[fidx_q] = 1'b0;
              held_d  = held_q - fword_q.size;
              count_d = count_q - 1'b1;
            end
            state_d = bbc_pkg::B_EVCHK;
          end
        end
      end

      bbc_pkg::B_EVCHK: begin
        if ((count_q != '0) && ((held_q > lim_q) || (count_q == FULL_CNT))) begin
          state_d = bbc_pkg::B_OLD;
          idx_d   = '0;
          bv_d    = 1'b0;
        end else begin
          state_d = bbc_pkg::B_FILL;
        end
      end

      bbc_pkg::B_OLD: begin
        if (pv_q && valid_q[pidx_q] && (!bv_q || (ram_rdata.stamp < bword_q.stamp))) begin
          bv_d    = 1'b1;
          bidx_d  = pidx_q;
          bword_d = ram_rdata;
        end
        if (scan_done) begin
          valid_d[bidx_q] = 1'b0;
          held_d  = held_q - bword_q.size;
          count_d = count_q - 1'b1;
          evict_d = evict_q + 1'b1;
          state_d = bbc_pkg::B_EVCHK;
        end
      end

      bbc_pkg::B_FILL: begin
        ram_we          = 1'b1;
        ram_waddr       = free_idx;
        ram_wdata.gen   = cmd_q.gen;
        ram_wdata.ord   = cmd_q.ord;
        ram_wdata.stage = cmd_q.stage;
        ram_wdata.size  = cmd_q.size;
        ram_wdata.href  = cmd_q.handle;
        ram_wdata.stamp = stamp_q;
        stamp_d         = stamp_q + 1'b1;
        valid_d[free_idx] = 1'b1;
        held_d   = held_q + cmd_q.size;
        count_d  = count_q + 1'b1;
        ov_d     = 1'b1;
        status_d = bbc_pkg::ST_STORED;
        total_d  = held_q + cmd_q.size;
        evc_d    = evict_q;
        state_d  = bbc_pkg::B_IDLE;
      end

      bbc_pkg::B_HIT: begin
        // Refresh the stamp so the entry becomes most recent.
        ram_we          = 1'b1;
        ram_waddr       = fidx_q;
        ram_wdata       = fword_q;
        ram_wdata.stamp = stamp_q;
        stamp_d         = stamp_q + 1'b1;
        ov_d     = 1'b1;
        status_d = bbc_pkg::ST_HIT;
        hit_d    = fword_q.href;
        total_d  = held_q;
        state_d  = bbc_pkg::B_IDLE;
      end

      default: begin
        state_d = bbc_pkg::B_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bbc_pkg::B_IDLE;
      idx_q   <= '0;
      pv_q    <= 1'b0;
      found_q <= 1'b0;
      bv_q    <= 1'b0;
      valid_q <= '0;
      count_q <= '0;
      held_q  <= '0;
      evict_q <= '0;
      stamp_q <= '0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      pv_q    <= pv_d;
      found_q <= found_d;
      bv_q    <= bv_d;
      valid_q <= valid_d;
      count_q <= count_d;
      held_q  <= held_d;
      evict_q <= evict_d;
      stamp_q <= stamp_d;
      ov_q    <= ov_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    pidx_q   <= pidx_d;
    fidx_q   <= fidx_d;
    fword_q  <= fword_d;
    bidx_q   <= bidx_d;
    bword_q  <= bword_d;
    lim_q    <= lim_d;
    status_q <= status_d;
    hit_q    <= hit_d;
    total_q  <= total_d;
    evc_q    <= evc_d;
  end

endmodule
